// ===== sv/sawsa_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sawsa_pkg
// shared types, field widths and saturating adders of the weighted sum and
// square accumulator
// ----------------------------------------------------------------------------
package sawsa_pkg;

  localparam int FUNC_W   = 2;
  localparam int COL_W    = 6;
  localparam int GENE_W   = 8;
  localparam int WEIGHT_W = 16;
  localparam int EXPR_W   = 16;
  localparam int WSUM_W   = 32;
  localparam int SUM_W    = 64;

  localparam int CFG_DW = 32;
  localparam int CFG_AW = 3;
  localparam int CIU_W  = 7;

  localparam logic [0:0]       REG_COLUMNS_IN_USE = 1'b0;
  localparam logic [CIU_W-1:0] COLUMNS_IN_USE_RST = 7'd64;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOAD  = 2'd0,
    FUNC_ACC   = 2'd1,
    FUNC_READ  = 2'd2,
    FUNC_CLEAR = 2'd3
  } func_e;

  typedef struct packed {
    logic             wr_en;
    logic [SUM_W-1:0] sum_linear;
    logic [SUM_W-1:0] sum_square;
  } mac_res_t;

  function automatic logic signed [SUM_W-1:0] sat_add64(input logic signed [SUM_W-1:0] a,
                                                        input logic signed [SUM_W-1:0] b);
    logic signed [SUM_W:0] s;
    s = (SUM_W+1)'(a) + (SUM_W+1)'(b);
    if (s[SUM_W] != s[SUM_W-1]) begin
      sat_add64 = s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      sat_add64 = s[SUM_W-1:0];
    end
  endfunction

  function automatic logic signed [WSUM_W-1:0] sat_add32(input logic signed [WSUM_W-1:0] a,
                                                         input logic signed [WSUM_W-1:0] b);
    logic signed [WSUM_W:0] s;
    s = (WSUM_W+1)'(a) + (WSUM_W+1)'(b);
    if (s[WSUM_W] != s[WSUM_W-1]) begin
      sat_add32 = s[WSUM_W] ? {1'b1, {(WSUM_W-1){1'b0}}} : {1'b0, {(WSUM_W-1){1'b1}}};
    end else begin
      sat_add32 = s[WSUM_W-1:0];
    end
  endfunction

endpackage
`default_nettype wire

// ===== sv/sawsa_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sawsa_if
// valid/ready channels for command items and read results
// ----------------------------------------------------------------------------
interface sawsa_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [sawsa_pkg::FUNC_W-1:0]         func;
  logic [sawsa_pkg::COL_W-1:0]          column_index;
  logic [sawsa_pkg::GENE_W-1:0]         gene_index;
  logic signed [sawsa_pkg::WEIGHT_W-1:0] weight;
  logic [sawsa_pkg::EXPR_W-1:0]         expr_value;

  modport source (output valid, func, column_index, gene_index, weight, expr_value,
                  input ready);
  modport sink (input valid, func, column_index, gene_index, weight, expr_value,
                output ready);
endinterface

interface sawsa_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [sawsa_pkg::WSUM_W-1:0] weight_sum;
  logic signed [sawsa_pkg::SUM_W-1:0]  sum_linear;
  logic signed [sawsa_pkg::SUM_W-1:0]  sum_square;

  modport source (output valid, weight_sum, sum_linear, sum_square, input ready);
  modport sink (input valid, weight_sum, sum_linear, sum_square, output ready);
endinterface
`default_nettype wire

// ===== sv/sawsa_apb.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sawsa_apb
// apb register port holding columns_in_use
// ----------------------------------------------------------------------------
module sawsa_apb (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [sawsa_pkg::CFG_AW-1:0]      paddr,
  input  logic [sawsa_pkg::CFG_DW-1:0]      pwdata,
  output logic [sawsa_pkg::CFG_DW-1:0]      prdata,
  output logic                              pready,
  output logic [sawsa_pkg::CIU_W-1:0]       columns_in_use_o
);

  logic [sawsa_pkg::CIU_W-1:0] ciu_q;
  logic                        sel_ciu;

  assign sel_ciu = (paddr[sawsa_pkg::CFG_AW-1:2] == sawsa_pkg::REG_COLUMNS_IN_USE);
  assign pready  = 1'b1;
  assign prdata  = sel_ciu ? sawsa_pkg::CFG_DW'(ciu_q) : '0;
  assign columns_in_use_o = ciu_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ciu_q <= sawsa_pkg::COLUMNS_IN_USE_RST;
    end else if (psel && penable && pwrite && pready && sel_ciu) begin
      ciu_q <= pwdata[sawsa_pkg::CIU_W-1:0];
    end
  end

endmodule
`default_nettype wire

// ===== sv/sawsa_mac.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sawsa_mac
// shared multiply-accumulate unit: one column per cycle, products registered,
// then saturating add of both sums
// ----------------------------------------------------------------------------
module sawsa_mac (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  valid_i,
  input  logic signed [sawsa_pkg::WEIGHT_W-1:0] weight_i,
  input  logic [sawsa_pkg::EXPR_W-1:0]          y_i,
  input  logic [2*sawsa_pkg::EXPR_W-1:0]        y2_i,
  input  logic signed [sawsa_pkg::SUM_W-1:0]    lin_i,
  input  logic signed [sawsa_pkg::SUM_W-1:0]    sq_i,
  output sawsa_pkg::mac_res_t                   res_o
);

  localparam int PL_W = sawsa_pkg::WEIGHT_W + sawsa_pkg::EXPR_W + 1;
  localparam int PS_W = sawsa_pkg::WEIGHT_W + 2*sawsa_pkg::EXPR_W + 1;

  logic signed [PL_W-1:0]             prod_lin_d, prod_lin_q;
  logic signed [PS_W-1:0]             prod_sq_d, prod_sq_q;
  logic signed [sawsa_pkg::SUM_W-1:0] lin_q, sq_q;
  logic                               valid_q;

  assign prod_lin_d = weight_i * $signed({1'b0, y_i});
  assign prod_sq_d  = weight_i * $signed({1'b0, y2_i});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_lin_q <= prod_lin_d;
    prod_sq_q  <= prod_sq_d;
    lin_q      <= lin_i;
    sq_q       <= sq_i;
  end

  always_comb begin
    res_o.wr_en      = valid_q;
    res_o.sum_linear = sawsa_pkg::sat_add64(lin_q, sawsa_pkg::SUM_W'(prod_lin_q));
    res_o.sum_square = sawsa_pkg::sat_add64(sq_q, sawsa_pkg::SUM_W'(prod_sq_q));
  end

endmodule
`default_nettype wire

// ===== sv/weighted_sum_and_square_accumulator_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// weighted_sum_and_square_accumulator_core
// load weight: stored and added, saturating, into its column's weight sum;
// read: result registered, then held until transferred; accumulate:
// n = min(columns_in_use, COLUMNS), one column per cycle through the shared
// multiply-accumulate unit and the read and write ports of each sum memory,
// skipped for a zero value, a gene out of range or n = 0; clear: zeroes all
// sums; reset starts the same sweep with in ready low; config writes anytime
// ----------------------------------------------------------------------------
module weighted_sum_and_square_accumulator_core #(
  parameter int COLUMNS = 64,
  parameter int GENES   = 256
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [sawsa_pkg::CFG_AW-1:0] paddr,
  input  logic [sawsa_pkg::CFG_DW-1:0] pwdata,
  output logic [sawsa_pkg::CFG_DW-1:0] prdata,
  output logic                         pready,
  sawsa_in_if.sink                     in_i,
  sawsa_out_if.source                  out_o
);

  localparam int CW     = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int GW     = (GENES > 1) ? $clog2(GENES) : 1;
  localparam int AW     = CW + GW;
  localparam int DEPTH  = 2**AW;
  localparam int CDEPTH = 2**CW;
  localparam int NW     = $clog2(COLUMNS + 1);

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_WSUM  = 5'b00100,
    ST_ACC   = 5'b01000,
    ST_READ  = 5'b10000
  } state_e;

  state_e  state_q, state_d;
  logic [AW-1:0] clr_q, clr_d;
  logic [NW-1:0] q_q, q_d;
  logic [NW-1:0] n_q, n_calc;

  logic [sawsa_pkg::CIU_W-1:0] columns_in_use;

  logic signed [sawsa_pkg::WEIGHT_W-1:0] cw_mem [CDEPTH];
  logic signed [sawsa_pkg::WSUM_W-1:0]   ws_mem [CDEPTH];
  logic signed [sawsa_pkg::SUM_W-1:0]    lin_mem [DEPTH];
  logic signed [sawsa_pkg::SUM_W-1:0]    sq_mem [DEPTH];

  logic signed [sawsa_pkg::WEIGHT_W-1:0] cw_rd_q;
  logic signed [sawsa_pkg::WSUM_W-1:0]   ws_rd_q;
  logic signed [sawsa_pkg::SUM_W-1:0]    lin_rd_q, sq_rd_q;

  logic [CW-1:0] col_q, s1_col_q, s2_col_q, col_in;
  logic [GW-1:0] gene_q, gene_in;
  logic          col_ok_q, gene_ok_q, col_in_ok, gene_in_ok;
  logic signed [sawsa_pkg::WEIGHT_W-1:0] wgt_q;
  logic [sawsa_pkg::EXPR_W-1:0]          y_q;
  logic [2*sawsa_pkg::EXPR_W-1:0]        y2_q;
  logic          s1_valid_q;

  logic          in_xfer, iss, out_load, out_valid_q;
  logic          cw_we, ws_we, ws_re, sum_we, sum_re;
  logic [CW-1:0] ws_wa, ws_ra;
  logic [AW-1:0] sum_wa, sum_ra;
  logic signed [sawsa_pkg::WSUM_W-1:0] ws_wd;
  logic signed [sawsa_pkg::SUM_W-1:0]  lin_wd, sq_wd;

  logic signed [sawsa_pkg::WSUM_W-1:0] out_ws_q;
  logic signed [sawsa_pkg::SUM_W-1:0]  out_lin_q, out_sq_q;

  sawsa_pkg::mac_res_t mac_res;

  sawsa_apb u_apb (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .columns_in_use_o (columns_in_use)
  );

  sawsa_mac u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (s1_valid_q),
    .weight_i (cw_rd_q),
    .y_i      (y_q),
    .y2_i     (y2_q),
    .lin_i    (lin_rd_q),
    .sq_i     (sq_rd_q),
    .res_o    (mac_res)
  );

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_xfer    = in_i.valid && in_i.ready;

  assign col_in_ok  = (32'(in_i.column_index) < 32'(COLUMNS));
  assign gene_in_ok = (32'(in_i.gene_index) < 32'(GENES));
  assign col_in     = CW'(in_i.column_index);
  assign gene_in    = GW'(in_i.gene_index);
  assign n_calc     = (32'(columns_in_use) > 32'(COLUMNS)) ? NW'(COLUMNS) : NW'(columns_in_use);

  assign iss      = (state_q == ST_ACC) && (q_q != n_q);
  assign out_load = (state_q == ST_READ) && (!out_valid_q || out_o.ready);

  // sequencer
  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    q_d     = q_q;
    case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (&clr_q) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_xfer) begin
          case (sawsa_pkg::func_e'(in_i.func))
            sawsa_pkg::FUNC_LOAD: begin
              if (col_in_ok) begin
                state_d = ST_WSUM;
              end
            end
            sawsa_pkg::FUNC_ACC: begin
              q_d = '0;
              if ((in_i.expr_value != '0) && gene_in_ok && (n_calc != '0)) begin
                state_d = ST_ACC;
              end
            end
            sawsa_pkg::FUNC_READ: begin
              state_d = ST_READ;
            end
            sawsa_pkg::FUNC_CLEAR: begin
              clr_d   = '0;
              state_d = ST_CLEAR;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_WSUM: begin
        state_d = ST_IDLE;
      end
      ST_ACC: begin
        if (q_q != n_q) begin
          q_d = q_q + 1'b1;
        end else if (!s1_valid_q) begin
          // last write lands at this edge
          state_d = ST_IDLE;
        end
      end
      ST_READ: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      q_q         <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      clr_q      <= clr_d;
      q_q        <= q_d;
      s1_valid_q <= iss;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      col_q     <= col_in;
      gene_q    <= gene_in;
      col_ok_q  <= col_in_ok;
      gene_ok_q <= gene_in_ok;
      wgt_q     <= in_i.weight;
      y_q       <= in_i.expr_value;
      y2_q      <= (2*sawsa_pkg::EXPR_W)'(in_i.expr_value) *
                   (2*sawsa_pkg::EXPR_W)'(in_i.expr_value);
      n_q       <= n_calc;
    end
    s1_col_q <= q_q[CW-1:0];
    s2_col_q <= s1_col_q;
    if (out_load) begin
      out_ws_q  <= col_ok_q ? ws_rd_q : '0;
      out_lin_q <= (col_ok_q && gene_ok_q) ? lin_rd_q : '0;
      out_sq_q  <= (col_ok_q && gene_ok_q) ? sq_rd_q : '0;
    end
  end

  // memory port selection
  always_comb begin
    cw_we = in_xfer && (in_i.func == sawsa_pkg::FUNC_LOAD) && col_in_ok;

    ws_re = in_xfer && ((in_i.func == sawsa_pkg::FUNC_LOAD) ||
                        (in_i.func == sawsa_pkg::FUNC_READ));
    ws_ra = col_in;
    ws_we = (state_q == ST_CLEAR) || (state_q == ST_WSUM);
    if (state_q == ST_CLEAR) begin
      ws_wa = clr_q[CW-1:0];
      ws_wd = '0;
    end else begin
      ws_wa = col_q;
      ws_wd = sawsa_pkg::sat_add32(ws_rd_q, sawsa_pkg::WSUM_W'(wgt_q));
    end

    sum_re = iss || (in_xfer && (in_i.func == sawsa_pkg::FUNC_READ));
    sum_ra = iss ? {q_q[CW-1:0], gene_q} : {col_in, gene_in};
    sum_we = (state_q == ST_CLEAR) || mac_res.wr_en;
    if (state_q == ST_CLEAR) begin
      sum_wa = clr_q;
      lin_wd = '0;
      sq_wd  = '0;
    end else begin
      sum_wa = {s2_col_q, gene_q};
      lin_wd = mac_res.sum_linear;
      sq_wd  = mac_res.sum_square;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cw_we) begin
      cw_mem[col_in] <= in_i.weight;
    end
    if (iss) begin
      cw_rd_q <= cw_mem[q_q[CW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ws_we) begin
      ws_mem[ws_wa] <= ws_wd;
    end
    if (ws_re) begin
      ws_rd_q <= ws_mem[ws_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (sum_we) begin
      lin_mem[sum_wa] <= lin_wd;
    end
    if (sum_re) begin
      lin_rd_q <= lin_mem[sum_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (sum_we) begin
      sq_mem[sum_wa] <= sq_wd;
    end
    if (sum_re) begin
      sq_rd_q <= sq_mem[sum_ra];
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.weight_sum = out_ws_q;
  assign out_o.sum_linear = out_lin_q;
  assign out_o.sum_square = out_sq_q;

endmodule
`default_nettype wire

// ===== sv/sawsa_chk.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sawsa_chk
// port-level checks of the accumulator core, bound to the top level
// ----------------------------------------------------------------------------
module sawsa_chk (
  input logic         clk_i,
  input logic         rst_ni,
  sawsa_in_if.sink    in_i,
  sawsa_out_if.source out_o
);

  logic in_xfer;

  assign in_xfer = in_i.valid && in_i.ready;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |=> out_o.valid)
    else $error("result dropped before transfer");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |=> $stable(out_o.weight_sum) &&
      $stable(out_o.sum_linear) && $stable(out_o.sum_square))
    else $error("stalled result changed");

  a_reset_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !in_i.ready)
    else $error("input ready before clearing sweep");

  a_clear_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && (in_i.func == sawsa_pkg::FUNC_CLEAR) |=> !in_i.ready)
    else $error("input ready right after clear");

  a_read_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> !$past(in_i.ready))
    else $error("result appeared without a read in progress");

endmodule

bind weighted_sum_and_square_accumulator_core sawsa_chk u_sawsa_chk (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .in_i   (in_i),
  .out_o  (out_o)
);
`default_nettype wire

// ===== tb/tb_weighted_sum_and_square_accumulator_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_weighted_sum_and_square_accumulator_core
// drives weight loads, accumulations, reads and clears into the core across
// several column counts, with random idle bursts and one long result stall.
// each read result is checked field by field against a predictor of the
// weight sums and the saturating linear and square sums
// ----------------------------------------------------------------------------
module tb_weighted_sum_and_square_accumulator_core;

  localparam int FUNC_W   = sawsa_pkg::FUNC_W;
  localparam int COL_W    = sawsa_pkg::COL_W;
  localparam int GENE_W   = sawsa_pkg::GENE_W;
  localparam int WEIGHT_W = sawsa_pkg::WEIGHT_W;
  localparam int EXPR_W   = sawsa_pkg::EXPR_W;
  localparam int WSUM_W   = sawsa_pkg::WSUM_W;
  localparam int SUM_W    = sawsa_pkg::SUM_W;
  localparam int CFG_AW   = sawsa_pkg::CFG_AW;
  localparam int CFG_DW   = sawsa_pkg::CFG_DW;
  localparam int CIU_W    = sawsa_pkg::CIU_W;

  localparam int CLK_PERIOD     = 2;
  localparam int COLS           = 64;
  localparam int GENES_N        = 256;
  localparam int SETTLE_CYCLES  = 80;
  localparam int HOLD_CYCLES    = 600;
  localparam int TIMEOUT_CYCLES = 1000000;
  localparam int PHASE_ITEMS    = 90;
  localparam longint WSUM_MAX   = 64'sd2147483647;
  localparam longint WSUM_MIN   = -64'sd2147483648;

  typedef struct {
    sawsa_pkg::func_e             func;
    logic [COL_W-1:0]             col;
    logic [GENE_W-1:0]            gene;
    logic signed [WEIGHT_W-1:0]   weight;
    logic [EXPR_W-1:0]            expr;
  } cmd_t;

  typedef struct {
    logic signed [WSUM_W-1:0] wsum;
    logic signed [SUM_W-1:0]  lin;
    logic signed [SUM_W-1:0]  sq;
  } sums_t;

  typedef struct {
    cmd_t cmd;
    bit   expect_zero;
  } vector_t;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  sawsa_in_if  in_if ();
  sawsa_out_if out_if ();

  weighted_sum_and_square_accumulator_core #(
    .COLUMNS (COLS),
    .GENES   (GENES_N)
  ) i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_i    (in_if),
    .out_o   (out_if)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // predictor state
  logic [CIU_W-1:0]           cols_in_use;
  logic signed [WEIGHT_W-1:0] cell_wt [COLS];
  bit                         cell_wt_seen [COLS];
  logic signed [WSUM_W-1:0]   wt_total [COLS];
  logic signed [SUM_W-1:0]    lin_acc [COLS*GENES_N];
  logic signed [SUM_W-1:0]    sq_acc [COLS*GENES_N];
  sums_t                      sums_due [$];

  int mismatches  = 0;
  int items_sent  = 0;
  int clears_left = 3;
  bit idle_on     = 1'b1;
  bit hold_start  = 1'b0;
  bit hold_done   = 1'b0;
  int hold_left   = 0;
  int stall_left  = 0;

  vector_t directed_tbl [25] = '{
    '{'{sawsa_pkg::FUNC_READ,  6'd0,  8'd0,   16'h0000, 16'h0000}, 1'b1},
    '{'{sawsa_pkg::FUNC_READ,  6'd63, 8'd255, 16'h0000, 16'h0000}, 1'b1},
    '{'{sawsa_pkg::FUNC_ACC,   6'd0,  8'd0,   16'h0000, 16'h0000}, 1'b0},
    '{'{sawsa_pkg::FUNC_LOAD,  6'd0,  8'd0,   16'h7fff, 16'h0000}, 1'b0},
    '{'{sawsa_pkg::FUNC_LOAD,  6'd0,  8'd0,   16'h7fff, 16'h0000}, 1'b0},
    '{'{sawsa_pkg::FUNC_ACC,   6'd0,  8'd0,   16'h0000, 16'hffff}, 1'b0},
    '{'{sawsa_pkg::FUNC_ACC,   6'd0,  8'd0,   16'h0000, 16'hffff}, 1'b0},
    '{'{sawsa_pkg::FUNC_READ,  6'd0,  8'd0,   16'h0000, 16'h0000}, 1'b0},
    '{'{sawsa_pkg::FUNC_LOAD,  6'd0,  8'd0,   16'h8000, 16'h0000}, 1'b0},
    '{'{sawsa_pkg::FUNC_ACC,   6'd0,  8'd255, 16'h0000, 16'hffff}, 1'b0},
    '{'{sawsa_pkg::FUNC_ACC,   6'd0,  8'd255, 16'h0000, 16'h0001}, 1'b0},
    '{'{sawsa_pkg::FUNC_READ,  6'd0,  8'd255, 16'h0000, 16'h0000}, 1'b0},
    '{'{sawsa_pkg::FUNC_LOAD,  6'd63, 8'd0,   16'hffff, 16'h0000}, 1'b0},
    '{'{sawsa_pkg::FUNC_LOAD,  6'd1,  8'd0,   16'h0001, 16'h0000}, 1'b0},
    '{'{sawsa_pkg::FUNC_ACC,   6'd0,  8'd128, 16'h0000, 16'h0000}, 1'b0},
    '{'{sawsa_pkg::FUNC_READ,  6'd63, 8'd255, 16'h0000, 16'h0000}, 1'b0},
    '{'{sawsa_pkg::FUNC_READ,  6'd1,  8'd0,   16'h0000, 16'h0000}, 1'b0},
    '{'{sawsa_pkg::FUNC_LOAD,  6'd0,  8'd0,   16'h4000, 16'h0000}, 1'b0},
    '{'{sawsa_pkg::FUNC_ACC,   6'd0,  8'd7,   16'h0000, 16'h8000}, 1'b0},
    '{'{sawsa_pkg::FUNC_READ,  6'd0,  8'd7,   16'h0000, 16'h0000}, 1'b0},
    '{'{sawsa_pkg::FUNC_CLEAR, 6'd0,  8'd0,   16'h0000, 16'h0000}, 1'b0},
    '{'{sawsa_pkg::FUNC_READ,  6'd0,  8'd7,   16'h0000, 16'h0000}, 1'b1},
    '{'{sawsa_pkg::FUNC_READ,  6'd63, 8'd255, 16'h0000, 16'h0000}, 1'b1},
    '{'{sawsa_pkg::FUNC_ACC,   6'd0,  8'd3,   16'h0000, 16'h0010}, 1'b0},
    '{'{sawsa_pkg::FUNC_READ,  6'd0,  8'd3,   16'h0000, 16'h0000}, 1'b0}
  };

  task automatic report(input string msg);
    if (mismatches < 40) begin
      $display("mismatch: %s", msg);
    end
    mismatches++;
  endtask

  function automatic logic signed [SUM_W-1:0] clamp_add(input logic signed [SUM_W-1:0] acc,
                                                        input logic signed [SUM_W-1:0] inc);
    logic signed [SUM_W-1:0] s;
    s = acc + inc;
    if (acc[SUM_W-1] == inc[SUM_W-1] && s[SUM_W-1] != acc[SUM_W-1]) begin
      s = acc[SUM_W-1] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end
    return s;
  endfunction

  function automatic void zero_sums();
    foreach (wt_total[i]) wt_total[i] = '0;
    foreach (lin_acc[i]) lin_acc[i] = '0;
    foreach (sq_acc[i]) sq_acc[i] = '0;
  endfunction

  function automatic void apply_cmd(input cmd_t c);
    int     idx;
    int     n;
    longint w;
    longint y;
    longint total;
    sums_t  r;
    case (c.func)
      sawsa_pkg::FUNC_LOAD: begin
        cell_wt[c.col]      = c.weight;
        cell_wt_seen[c.col] = 1'b1;
        total = longint'(wt_total[c.col]) + longint'(c.weight);
        if (total > WSUM_MAX) total = WSUM_MAX;
        if (total < WSUM_MIN) total = WSUM_MIN;
        wt_total[c.col] = total[WSUM_W-1:0];
      end
      sawsa_pkg::FUNC_ACC: begin
        if (c.expr != '0) begin
          n = (cols_in_use > COLS) ? COLS : int'(cols_in_use);
          y = longint'(c.expr);
          for (int q = 0; q < n; q++) begin
            idx = q * GENES_N + int'(c.gene);
            w = longint'(cell_wt[q]);
            lin_acc[idx] = clamp_add(lin_acc[idx], w * y);
            sq_acc[idx]  = clamp_add(sq_acc[idx], w * y * y);
          end
        end
      end
      sawsa_pkg::FUNC_READ: begin
        idx    = int'(c.col) * GENES_N + int'(c.gene);
        r.wsum = wt_total[c.col];
        r.lin  = lin_acc[idx];
        r.sq   = sq_acc[idx];
        sums_due.push_back(r);
      end
      default: begin
        zero_sums();
      end
    endcase
  endfunction

  function automatic cmd_t mk_cmd(input sawsa_pkg::func_e f, input int col, input int gene,
                                  input logic [WEIGHT_W-1:0] w, input logic [EXPR_W-1:0] e);
    cmd_t c;
    c.func   = f;
    c.col    = COL_W'(col);
    c.gene   = GENE_W'(gene);
    c.weight = w;
    c.expr   = e;
    return c;
  endfunction

  function automatic logic [WEIGHT_W-1:0] rand_weight();
    case ($urandom_range(0, 5))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return WEIGHT_W'($urandom_range(0, 31) - 16);
      default: return WEIGHT_W'($urandom);
    endcase
  endfunction

  function automatic logic [EXPR_W-1:0] rand_expr();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return 16'hffff;
      2: return EXPR_W'($urandom_range(1, 16));
      default: return EXPR_W'($urandom);
    endcase
  endfunction

  // genes mostly from a small pool so reads land on accumulated entries
  function automatic int rand_gene();
    return ($urandom_range(0, 3) == 0) ? $urandom_range(0, GENES_N - 1) : $urandom_range(0, 7);
  endfunction

  task automatic push_cmd(input cmd_t c);
    int gap;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_if.valid <= 1'b0;
      gap = $urandom_range(1, 18);
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.func         <= c.func;
    in_if.column_index <= c.col;
    in_if.gene_index   <= c.gene;
    in_if.weight       <= c.weight;
    in_if.expr_value   <= c.expr;
    do @(posedge clk_i); while (!in_if.ready);
    apply_cmd(c);
    items_sent++;
  endtask

  task automatic write_columns_in_use(input logic [CIU_W-1:0] val);
    logic [CFG_AW-1:0] addr;
    addr = CFG_AW'(4 * sawsa_pkg::REG_COLUMNS_IN_USE);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= CFG_DW'(val);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    cols_in_use = val;
    // read back
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[CIU_W-1:0] !== val) begin
      report($sformatf("columns_in_use read back %0d, wrote %0d", prdata[CIU_W-1:0], val));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (sums_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // one cell: load weights in use that are unset or picked at random, then stream values with reads mixed in
  task automatic run_cell();
    int   n;
    int   k;
    int   col;
    cmd_t c;
    n = (cols_in_use > COLS) ? COLS : int'(cols_in_use);
    for (int q = 0; q < n; q++) begin
      if (!cell_wt_seen[q] || $urandom_range(0, 3) == 0) begin
        push_cmd(mk_cmd(sawsa_pkg::FUNC_LOAD, q, $urandom_range(0, GENES_N - 1), rand_weight(),
                        EXPR_W'($urandom)));
      end
    end
    if ($urandom_range(0, 2) == 0) begin
      push_cmd(mk_cmd(sawsa_pkg::FUNC_LOAD, $urandom_range(0, COLS - 1), rand_gene(),
                      rand_weight(), EXPR_W'($urandom)));
    end
    k = $urandom_range(1, 6);
    for (int j = 0; j < k; j++) begin
      push_cmd(mk_cmd(sawsa_pkg::FUNC_ACC, $urandom_range(0, COLS - 1), rand_gene(),
                      WEIGHT_W'($urandom), rand_expr()));
      if ($urandom_range(0, 2) == 0) begin
        col = (n > 0 && $urandom_range(0, 3) != 0) ? $urandom_range(0, n - 1)
                                                   : $urandom_range(0, COLS - 1);
        push_cmd(mk_cmd(sawsa_pkg::FUNC_READ, col, rand_gene(), WEIGHT_W'($urandom),
                        EXPR_W'($urandom)));
      end
    end
    if ($urandom_range(0, 9) == 0) begin
      c = mk_cmd(sawsa_pkg::func_e'(FUNC_W'($urandom_range(0, 3))), $urandom_range(0, COLS - 1),
                 $urandom_range(0, GENES_N - 1), WEIGHT_W'($urandom), EXPR_W'($urandom));
      if (c.func == sawsa_pkg::FUNC_CLEAR) begin
        if (clears_left > 0) clears_left--;
        else c.func = sawsa_pkg::FUNC_READ;
      end
      push_cmd(c);
    end
  endtask

  task automatic run_phase(input logic [CIU_W-1:0] ciu, input bit with_hold);
    int start;
    write_columns_in_use(ciu);
    if (with_hold) hold_start = 1'b1;
    start = items_sent;
    while (items_sent - start < PHASE_ITEMS) run_cell();
    // a closing read proves the core has finished all earlier work
    push_cmd(mk_cmd(sawsa_pkg::FUNC_READ, $urandom_range(0, COLS - 1), rand_gene(),
                    WEIGHT_W'($urandom), EXPR_W'($urandom)));
    drain();
  endtask

  // result side: ready pattern and checks
  always @(posedge clk_i) begin : rx
    sums_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (sums_due.size() == 0) begin
        report("result transfer with nothing expected");
      end else begin
        want = sums_due.pop_front();
        if (out_if.weight_sum !== want.wsum) begin
          report($sformatf("weight_sum got %h expected %h", out_if.weight_sum, want.wsum));
        end
        if (out_if.sum_linear !== want.lin) begin
          report($sformatf("sum_linear got %h expected %h", out_if.sum_linear, want.lin));
        end
        if (out_if.sum_square !== want.sq) begin
          report($sformatf("sum_square got %h expected %h", out_if.sum_square, want.sq));
        end
      end
    end
    if (hold_start && !hold_done) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_if.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 18) - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  initial begin
    rst_ni             = 1'b0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    in_if.valid        = 1'b0;
    in_if.func         = sawsa_pkg::FUNC_LOAD;
    in_if.column_index = '0;
    in_if.gene_index   = '0;
    in_if.weight       = '0;
    in_if.expr_value   = '0;
    out_if.ready       = 1'b0;
    cols_in_use        = sawsa_pkg::COLUMNS_IN_USE_RST;
    foreach (cell_wt[i]) begin
      cell_wt[i]      = '0;
      cell_wt_seen[i] = 1'b0;
    end
    zero_sums();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_columns_in_use(7'd1);
    foreach (directed_tbl[i]) begin
      push_cmd(directed_tbl[i].cmd);
      if (directed_tbl[i].expect_zero) begin
        sums_due[sums_due.size()-1] = '{default: '0};
      end
    end
    drain();

    run_phase(7'd7, 1'b1);
    run_phase(7'd64, 1'b0);
    run_phase(7'd0, 1'b0);
    run_phase(7'd127, 1'b0);
    run_phase(CIU_W'($urandom_range(1, COLS)), 1'b0);
    // closing stretch with no idling on either side
    idle_on = 1'b0;
    run_phase(7'd64, 1'b0);

    if (mismatches == 0 && sums_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    repeat (TIMEOUT_CYCLES) @(posedge clk_i);
    $display("timeout");
    $display("== FAIL ==");
    $finish;
  end

endmodule
